### hw/rtl/sli_pkg.sv
// sli_pkg: shared types and constants for the sorted list insert/delete unit
// payload structs, status and op codes, and cell control types
// no dependencies
package sli_pkg;

   // default list depth
   localparam int DEPTH_DEF = 16;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // input item
   typedef struct packed {
      logic               op;
      logic signed [31:0] value;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [4:0] count;
      logic       empty_res;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic               ins_en;
      logic               del_en;
      logic signed [31:0] value;
   } sli_bcast_type;

   // per-cell compare flags
   typedef struct packed {
      logic after;   // insert lands at or before this cell
      logic match;   // valid entry equal to the value
      logic ge;      // entry not below the value
   } sli_flag_type;

endpackage

### hw/rtl/sli_cell.sv
// sli_cell: one slot of the sorted list, compares the broadcast value
// and shifts with its neighbors on insert or delete
// depends on sli_pkg
module sli_cell
   import sli_pkg::*;
(
   input  logic               clock,
   input  sli_bcast_type      bcast,
   input  logic               slot_valid,
   input  logic               left_after,
   input  logic signed [31:0] left_entry,
   input  logic signed [31:0] right_entry,
   output logic signed [31:0] entry,
   output sli_flag_type       flags
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   // compare against the broadcast value
   always_comb begin
      flags.after = !slot_valid || (entry_ff > bcast.value);
      flags.match = slot_valid && (entry_ff == bcast.value);
      flags.ge    = !(entry_ff < bcast.value);
   end

   // next entry: shift up, take the value, or shift down
   always_comb begin
      entry_in = entry_ff;
      if (bcast.ins_en) begin
         if (left_after) begin
            entry_in = left_entry;
         end else if (flags.after) begin
            entry_in = bcast.value;
         end
      end else if (bcast.del_en && flags.ge) begin
         entry_in = right_entry;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/sorted_list_insert_delete_unit.sv
// sorted list insert/delete unit: a row of DEPTH cells holds the ascending list
// the result is registered in the cycle after the input transfer
// throughput: one item per cycle while the result register drains, with the compare and shift done in the cells
// reset: synchronous, clears the fill count and the result valid; entries are not cleared
// depends on sli_pkg and sli_cell
module sorted_list_insert_delete_unit
   import sli_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = (IDX_W > 4) ? IDX_W : 4;
   localparam int CNX_W = (CNT_W > 5) ? CNT_W : 5;

   logic [CNT_W-1:0]   held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               full;
   logic               found;
   sli_bcast_type      bcast;
   logic signed [31:0] entry [DEPTH];
   sli_flag_type       flags [DEPTH];
   logic [DEPTH-1:0]   slot_valid;
   logic [DEPTH-1:0]   match_vec;
   logic [DEPTH-1:0]   ins_first;
   logic [DEPTH-1:0]   del_first;
   logic [POS_W-1:0]   ins_pos, del_pos, pos_sel;
   logic [CNX_W-1:0]   held_ext;

   // handshake: output register frees as it drains
   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign full      = (held_ff == CNT_W'(DEPTH));

   // valid slots and match summary
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_valid[i] = held_ff > CNT_W'(i);
         match_vec[i]  = flags[i].match;
      end
   end
   assign found = |match_vec;

   // broadcast to the cells
   always_comb begin
      bcast.value  = req_data.value;
      bcast.ins_en = accept && (req_data.op == OP_INSERT) && !full;
      bcast.del_en = accept && (req_data.op == OP_DELETE) && found;
   end

   // cell row
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic               left_after;
         logic signed [31:0] left_entry;
         logic signed [31:0] right_entry;
         if (g == 0) begin : g_first
            assign left_after = 1'b0;
            assign left_entry = req_data.value;
         end else begin : g_mid
            assign left_after = flags[g-1].after;
            assign left_entry = entry[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_entry = entry[g];
         end else begin : g_inner
            assign right_entry = entry[g+1];
         end
         sli_cell u_cell (
            .clock       (clock),
            .bcast       (bcast),
            .slot_valid  (slot_valid[g]),
            .left_after  (left_after),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry[g]),
            .flags       (flags[g])
         );
      end
   endgenerate

   // first-cell one-hots for insert slot and delete match
   always_comb begin
      ins_first[0] = flags[0].after;
      del_first[0] = flags[0].match;
      for (int i = 1; i < DEPTH; i++) begin
         ins_first[i] = flags[i].after && !flags[i-1].after;
         del_first[i] = flags[i].match && !flags[i-1].match;
      end
   end

   // encode positions from the one-hots
   always_comb begin
      ins_pos = '0;
      del_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ins_pos = ins_pos | (ins_first[i] ? POS_W'(i) : '0);
         del_pos = del_pos | (del_first[i] ? POS_W'(i) : '0);
      end
   end

   // result and fill count
   always_comb begin
      held_in       = held_ff;
      pos_sel       = '0;
      rsp_in.status = ST_DONE;
      if (req_data.op == OP_INSERT) begin
         if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            pos_sel = ins_pos;
            held_in = held_ff + CNT_W'(1);
         end
      end else begin
         if (found) begin
            pos_sel = del_pos;
            held_in = held_ff - CNT_W'(1);
         end else begin
            rsp_in.status = ST_NOT_FOUND;
         end
      end
      held_ext         = CNX_W'(held_in);
      rsp_in.position  = pos_sel[3:0];
      rsp_in.count     = held_ext[4:0];
      rsp_in.empty_res = (held_in == '0);
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            held_ff <= held_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### test/sorted_list_insert_delete_unit_test.sv
// testbench for sorted_list_insert_delete_unit: directed and random inserts and deletes
// checks every result against a behavioral sorted list kept in the bench
// depends on sli_pkg and the unit rtl
module sorted_list_insert_delete_unit_test
   import sli_pkg::*;
();

   localparam int LIST_DEPTH   = DEPTH_DEF;
   localparam int RANDOM_ITEMS = 450;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_FROM   = 250;
   localparam int QUIET_TO     = 350;
   localparam int SHOWN_ERRORS = 10;

   typedef logic signed [31:0] list_word;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // items waiting to be offered, and the results they should produce
   req_type  pending_items[$];
   rsp_type  expected_rsps[$];
   // bench copy of the sorted list
   list_word sorted_vals[$];
   // values believed held, used only to aim deletes at hits
   list_word held_bag[$];

   int      total_items = 0;
   int      accepted_reqs = 0;
   int      stall_cycles = 0;
   int      mismatches = 0;
   int      hold_left = 0;
   logic    hold_done = 1'b0;
   logic    quiet;
   rsp_type want_rsp;

   sorted_list_insert_delete_unit #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // stretch with no idling on either side
   assign quiet = (accepted_reqs >= QUIET_FROM) && (accepted_reqs < QUIET_TO);

   // apply one operation to the bench list and return the result it gives
   function automatic rsp_type apply_list_op(req_type item);
      rsp_type  r;
      list_word v;
      int       slot;
      int       i;
      logic     hit;
      r = '0;
      v = item.value;
      slot = 0;
      hit = 1'b0;
      if (item.op == OP_INSERT) begin
         if (sorted_vals.size() >= LIST_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // lands after every equal entry
            slot = sorted_vals.size();
            for (i = 0; i < sorted_vals.size(); i++) begin
               if (sorted_vals[i] > v) begin
                  slot = i;
                  break;
               end
            end
            sorted_vals.insert(slot, v);
            r.status = ST_DONE;
            r.position = slot[3:0];
         end
      end else begin
         // lowest-index equal entry goes
         for (i = 0; i < sorted_vals.size(); i++) begin
            if (sorted_vals[i] == v) begin
               slot = i;
               hit = 1'b1;
               break;
            end
         end
         if (hit) begin
            sorted_vals.delete(slot);
            r.status = ST_DONE;
            r.position = slot[3:0];
         end else begin
            r.status = ST_NOT_FOUND;
         end
      end
      r.count = 5'(sorted_vals.size());
      r.empty_res = (sorted_vals.size() == 0);
      return r;
   endfunction

   // queue one item and track what the list should hold
   task automatic queue_item(logic op, list_word v);
      req_type item;
      int      i;
      item.op = op;
      item.value = v;
      pending_items.push_back(item);
      total_items++;
      if (op == OP_INSERT) begin
         if (held_bag.size() < LIST_DEPTH) held_bag.push_back(v);
      end else begin
         for (i = 0; i < held_bag.size(); i++) begin
            if (held_bag[i] == v) begin
               held_bag.delete(i);
               break;
            end
         end
      end
   endtask

   // small values for duplicates in four of ten picks, extremes in one, the rest anything
   function automatic list_word pick_value();
      list_word v;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            v = $signed($urandom_range(8)) - 4;
         end
         4: begin
            case ($urandom_range(5))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7fff_ffff;
               2: v = 32'sh8000_0001;
               3: v = 32'sh7fff_fffe;
               4: v = 32'sh0000_0000;
               default: v = -32'sd1;
            endcase
         end
         default: begin
            v = $urandom();
         end
      endcase
      return v;
   endfunction

   // stimulus, reset and end of run
   initial begin
      int  n;
      int  mode;
      int  len;
      int  k;
      int  ins_pct;
      logic op;
      list_word v;

      // directed: empty delete, extremes, duplicates, misses, fill to full
      queue_item(OP_DELETE, 32'sd0);
      queue_item(OP_INSERT, 32'sh7fff_ffff);
      queue_item(OP_INSERT, 32'sh8000_0000);
      queue_item(OP_INSERT, 32'sd0);
      queue_item(OP_INSERT, 32'sd5);
      queue_item(OP_INSERT, 32'sd5);
      queue_item(OP_INSERT, -32'sd1);
      queue_item(OP_DELETE, 32'sd5);
      queue_item(OP_DELETE, 32'sd1234);
      queue_item(OP_DELETE, 32'sh8000_0000);
      queue_item(OP_DELETE, 32'sh7fff_ffff);
      queue_item(OP_INSERT, 32'sh5555_5555);
      queue_item(OP_INSERT, 32'shaaaa_aaaa);
      for (k = 0; k < 10; k++) queue_item(OP_INSERT, 32'sd7);
      queue_item(OP_INSERT, 32'sh7fff_fffe);
      queue_item(OP_INSERT, 32'sh7fff_ffff);

      // random episodes that fill, drain or mix
      n = 0;
      while (n < RANDOM_ITEMS) begin
         mode = $urandom_range(2);
         len = $urandom_range(8, 40);
         ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
         for (k = 0; k < len && n < RANDOM_ITEMS; k++) begin
            op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE;
            if (op == OP_DELETE && held_bag.size() > 0 && $urandom_range(3) != 0)
               v = held_bag[$urandom_range(held_bag.size() - 1)];
            else
               v = pick_value();
            queue_item(op, v);
            n++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_reqs < total_items || expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // driver: offer the next item when the previous one transferred
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 35)) begin
            req_valid <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold so the unit backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 35);
      end
   end

   // monitor: check result transfers, predict on input transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("unexpected result: status %0d position %0d count %0d empty %0b",
                           rsp_data.status, rsp_data.position, rsp_data.count,
                           rsp_data.empty_res);
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_data.status !== want_rsp.status ||
                   rsp_data.position !== want_rsp.position ||
                   rsp_data.count !== want_rsp.count ||
                   rsp_data.empty_res !== want_rsp.empty_res) begin
                  mismatches++;
                  if (mismatches <= SHOWN_ERRORS) begin
                     $write("result mismatch: expected status %0d position %0d count %0d",
                            want_rsp.status, want_rsp.position, want_rsp.count);
                     $write(" empty %0b, got status %0d position %0d",
                            want_rsp.empty_res, rsp_data.status, rsp_data.position);
                     $display(" count %0d empty %0b", rsp_data.count, rsp_data.empty_res);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(apply_list_op(req_data));
            accepted_reqs <= accepted_reqs + 1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // watchdog on cycles with no transfer at all
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

endmodule
